// File: hw/rtl/pcm_linear_interp_resampler_macros.svh
// Assertion helpers used by the resampler RTL.
`ifndef PCM_LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define PCM_LINEAR_INTERP_RESAMPLER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PCMLI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PCMLI_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hw/rtl/pcmli_pkg.sv
package pcmli_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SIXTEEN_BIT = 2'd0;
  localparam logic [1:0] REG_STEREO      = 2'd1;
  localparam logic [1:0] REG_RATE_STEP   = 2'd2;

  // Step limits and one source frame, unsigned 3.16
  localparam logic [18:0] STEP_MIN   = 19'd2048;
  localparam logic [18:0] STEP_MAX   = 19'd262144;
  localparam logic [18:0] STEP_RESET = 19'd65536;
  localparam logic [18:0] ONE_FRAME  = 19'd65536;

  // Fraction is consumed as four 4-bit digits, low digit first
  localparam int DIGIT_W     = 4;
  localparam int FRAC_DIGITS = 4;

  // Signed 16-bit output limits, sign-extended to the 19-bit interpolator total
  localparam logic signed [18:0] SAMPLE_MAX = 19'sd32767;
  localparam logic signed [18:0] SAMPLE_MIN = -19'sd32768;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_OUT,
    S_MARK
  } state_t;

endpackage

// File: hw/rtl/pcmli_interp.sv
module pcmli_interp
  import pcmli_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic               adv,
  input  logic signed [15:0] s0_in,
  input  logic signed [15:0] s1_in,
  input  logic [15:0]        frac,
  output logic signed [15:0] sample
);

  logic signed [15:0] s0;
  logic signed [16:0] diff;
  logic [15:0]        frac_sr;
  logic signed [17:0] acc;

  logic signed [21:0] prod;
  logic signed [21:0] sum;
  logic signed [18:0] total;

  // Multiply the difference by one fraction digit and fold into the accumulator
  assign prod = $signed({{5{diff[16]}}, diff}) * $signed({18'd0, frac_sr[DIGIT_W-1:0]});
  assign sum  = {{4{acc[17]}}, acc} + prod;

  // Latch the operands, then shift one digit per cycle under adv; the accumulator keeps the floor
  always_ff @(posedge clk) begin
    if (load) begin
      s0      <= s0_in;
      diff    <= {s1_in[15], s1_in} - {s0_in[15], s0_in};
      frac_sr <= frac;
      acc     <= '0;
    end else if (adv) begin
      acc     <= sum[21:4];
      frac_sr <= frac_sr >> DIGIT_W;
    end
  end

  // Add the scaled difference to the older sample and clamp to 16 bits
  assign total = {{3{s0[15]}}, s0} + {acc[17], acc};

  always_comb begin
    if (total > SAMPLE_MAX) begin
      sample = SAMPLE_MAX[15:0];
    end else if (total < SAMPLE_MIN) begin
      sample = SAMPLE_MIN[15:0];
    end else begin
      sample = total[15:0];
    end
  end

endmodule

// File: hw/rtl/pcm_linear_interp_resampler.sv
// Channel  | Direction | Transfer carries
// s_*      | in        | tdata = left_raw, right_raw; tlast = last_frame
// m_*      | out       | tdata = left_out, right_out; tuser = has_frame; tlast = end_of_stream
// cfg_*    | in        | register index and value, one write per cycle with cfg_we
//
// Each output frame takes a position check, the digit-serial multiply (one 4-bit
// fraction digit per cycle) and a step that loads the output register. An input frame
// that follows a held one takes its accept step, those steps per output frame and a check
// closing its interval; the last one adds a tail check, and a mark step for a bare end mark.
// s_tready is high only between frames; the output register lets the next frame be
// accepted while the last result waits. A stalled m_tready holds the sequencer in its
// output step. Synchronous reset clears position and held frame, and sets register defaults.
`include "pcm_linear_interp_resampler_macros.svh"

module pcm_linear_interp_resampler
  import pcmli_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] left_raw, [31:16] right_raw
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] left_out, [31:16] right_out
  output logic [0:0]  m_tuser,   // [0] has_frame
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [18:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic        sixteen_bit;
  logic        stereo;
  logic [18:0] rate_step;

  logic [18:0] pos;
  logic        have_prev;
  logic        last_r;
  logic        tail;
  logic        any_out;
  logic [1:0]  cnt;

  logic signed [15:0] prev_left;
  logic signed [15:0] prev_right;
  logic signed [15:0] cur_left;
  logic signed [15:0] cur_right;

  logic signed [15:0] dec_left;
  logic signed [15:0] dec_right;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [18:0]        step_clamped;
  logic [18:0]        pos_step;
  logic               in_span;
  logic               end_flag;

  logic accept;
  logic out_load;
  logic unit_load;
  logic unit_adv;

  // Decode raw samples: 8-bit unsigned becomes (b - 128) << 8
  always_comb begin
    if (sixteen_bit) begin
      dec_left  = s_tdata[15:0];
      dec_right = s_tdata[31:16];
    end else begin
      dec_left  = {~s_tdata[7], s_tdata[6:0], 8'h00};
      dec_right = {~s_tdata[23], s_tdata[22:16], 8'h00};
    end
    if (!stereo) begin
      dec_right = dec_left;
    end
  end

  // Clamp the step value on write
  always_comb begin
    step_clamped = cfg_data;
    if (cfg_data < STEP_MIN) begin
      step_clamped = STEP_MIN;
    end else if (cfg_data > STEP_MAX) begin
      step_clamped = STEP_MAX;
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign in_span  = (pos[18:16] == 3'd0);
  assign pos_step = pos + rate_step;

  // Flag the last frame of the stream: the tail ends, or an empty tail follows
  assign end_flag = last_r && (tail ? (pos_step[18:16] != 3'd0) : (pos_step[18:17] != 2'd0));

  // Sequencer outputs
  always_comb begin
    s_tready  = (state == S_IDLE);
    unit_load = (state == S_CHECK) && in_span;
    unit_adv  = (state == S_MUL);
    out_load  = ((state == S_OUT) || (state == S_MARK)) && (!m_tvalid || m_tready);
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (have_prev || s_tlast)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (in_span) begin
          state_next = S_MUL;
        end else if (!tail) begin
          state_next = last_r ? S_CHECK : S_IDLE;
        end else begin
          state_next = any_out ? S_IDLE : S_MARK;
        end
      end
      S_MUL: begin
        if (cnt == 2'(FRAC_DIGITS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_CHECK;
        end
      end
      S_MARK: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state, position and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sixteen_bit <= 1'b1;
      stereo      <= 1'b1;
      rate_step   <= STEP_RESET;
      pos         <= '0;
      have_prev   <= 1'b0;
      last_r      <= 1'b0;
      tail        <= 1'b0;
      any_out     <= 1'b0;
      cnt         <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      // Take configuration writes; unknown indexes drop
      if (cfg_we) begin
        case (cfg_index)
          REG_SIXTEEN_BIT: sixteen_bit <= cfg_data[0];
          REG_STEREO:      stereo      <= cfg_data[0];
          REG_RATE_STEP:   rate_step   <= step_clamped;
          default: ;
        endcase
      end

      // Output register valid: set on load, clear on transfer
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            last_r  <= s_tlast;
            any_out <= 1'b0;
            if (have_prev) begin
              tail <= 1'b0;
            end else begin
              have_prev <= 1'b1;
              tail      <= 1'b1;
            end
          end
        end
        S_CHECK: begin
          if (in_span) begin
            cnt <= '0;
          end else if (!tail) begin
            pos  <= pos - ONE_FRAME;
            tail <= 1'b1;
          end else if (any_out) begin
            pos       <= '0;
            have_prev <= 1'b0;
          end
        end
        S_MUL: begin
          cnt <= cnt + 2'd1;
        end
        S_OUT: begin
          if (out_load) begin
            pos     <= pos_step;
            any_out <= 1'b1;
          end
        end
        S_MARK: begin
          if (out_load) begin
            pos       <= '0;
            have_prev <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Held frames and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_left  <= dec_left;
      cur_right <= dec_right;
      if (!have_prev) begin
        prev_left  <= dec_left;
        prev_right <= dec_right;
      end
    end
    // Advance the held frame once its interval is used up
    if ((state == S_CHECK) && !in_span && !tail) begin
      prev_left  <= cur_left;
      prev_right <= cur_right;
    end
    if (out_load) begin
      if (state == S_MARK) begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= {right_sample, left_sample};
        m_tuser <= 1'b1;
        m_tlast <= end_flag;
      end
    end
  end

  pcmli_interp u_interp_left (
    .clk    (clk),
    .load   (unit_load),
    .adv    (unit_adv),
    .s0_in  (prev_left),
    .s1_in  (cur_left),
    .frac   ({pos[15:1], 1'b0}),
    .sample (left_sample)
  );

  pcmli_interp u_interp_right (
    .clk    (clk),
    .load   (unit_load),
    .adv    (unit_adv),
    .s0_in  (prev_right),
    .s1_in  (cur_right),
    .frac   ({pos[15:1], 1'b0}),
    .sample (right_sample)
  );

  `PCMLI_ASSERT(a_mul_in_span, clk, rst, (state == S_MUL) |-> in_span, "multiply out of span")
  `PCMLI_ASSERT(a_empty_pos_zero, clk, rst, !have_prev |-> (pos == '0), "stray position")
  `PCMLI_ASSERT(a_step, clk, rst, rate_step >= STEP_MIN && rate_step <= STEP_MAX, "bad step")
  `PCMLI_NEVER(a_marker_ends, clk, rst, m_tvalid && !m_tuser[0] && !m_tlast, "end mark missing")

endmodule

// File: tb/sv/tb_pcm_linear_interp_resampler.sv
module tb_pcm_linear_interp_resampler
  import pcmli_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_RESULTS    = 64;
  localparam int         QUIET_CYCLES   = 32;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         MAX_PRINTED    = 50;
  localparam logic [1:0] REG_UNUSED     = 2'd3;

  // One output frame as the block presents it
  typedef struct packed {
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic        has_frame;
    logic        end_of_stream;
  } out_frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;     // [15:0] left_raw, [31:16] right_raw
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [15:0] left_out, [31:16] right_out
  logic [0:0]  m_tuser;          // [0] has_frame
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [18:0] cfg_data = '0;

  // Register copies and resampler state kept by the predictor
  logic        cfg_sixteen = 1'b1;
  logic        cfg_stereo  = 1'b1;
  logic [18:0] cfg_step    = STEP_RESET;
  logic [18:0] pos         = '0;
  int          held_left   = 0;
  int          held_right  = 0;
  logic        held_valid  = 1'b0;

  out_frame_t  expected_frames[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles    = 0;

  pcm_linear_interp_resampler u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // Source byte or word to signed 16-bit sample
  function automatic int decode_sample_raw(logic [15:0] raw);
    if (cfg_sixteen) return int'(signed'(raw));
    return (int'(raw[7:0]) - 128) * 256;
  endfunction

  // Linear blend with a 15-bit fraction, floor shift, 16-bit clamp
  function automatic int blend_sample(int s0, int s1, logic [15:0] frac);
    longint prod;
    int     sum;
    prod = longint'(s1 - s0) * longint'(frac[15:1]);
    sum  = s0 + int'(prod >>> 15);
    if (sum > 32767) return 32767;
    if (sum < -32768) return -32768;
    return sum;
  endfunction

  function automatic out_frame_t pack_result(int l, int r, logic has, logic eos);
    out_frame_t f;
    f.left_out      = l[15:0];
    f.right_out     = r[15:0];
    f.has_frame     = has;
    f.end_of_stream = eos;
    return f;
  endfunction

  // Queue every output frame that one accepted source frame causes
  task automatic predict_source_frame(logic [15:0] l_raw, logic [15:0] r_raw, logic last);
    int         cur_left;
    int         cur_right;
    int         n;
    out_frame_t tail;
    cur_left  = decode_sample_raw(l_raw);
    cur_right = cfg_stereo ? decode_sample_raw(r_raw) : cur_left;
    n = 0;
    // interpolate across the interval that ends at this frame
    if (held_valid) begin
      while (pos[18:16] == 3'd0 && n < MAX_RESULTS) begin
        expected_frames.push_back(pack_result(blend_sample(held_left, cur_left, pos[15:0]),
                                              blend_sample(held_right, cur_right, pos[15:0]),
                                              1'b1, 1'b0));
        n++;
        pos = pos + cfg_step;
      end
      pos = pos - ONE_FRAME;
    end
    held_left  = cur_left;
    held_right = cur_right;
    held_valid = 1'b1;
    if (last) begin
      // flush the positions left inside the final frame
      while (pos[18:16] == 3'd0 && n < MAX_RESULTS) begin
        expected_frames.push_back(pack_result(held_left, held_right, 1'b1, 1'b0));
        n++;
        pos = pos + cfg_step;
      end
      if (n > 0) begin
        tail = expected_frames.pop_back();
        tail.end_of_stream = 1'b1;
        expected_frames.push_back(tail);
      end else begin
        expected_frames.push_back(pack_result(0, 0, 1'b0, 1'b1));
      end
      pos        = '0;
      held_left  = 0;
      held_right = 0;
      held_valid = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(logic [1:0] idx, logic [18:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SIXTEEN_BIT: cfg_sixteen = value[0];
      REG_STEREO:      cfg_stereo  = value[0];
      REG_RATE_STEP: begin
        if (value < STEP_MIN) cfg_step = STEP_MIN;
        else if (value > STEP_MAX) cfg_step = STEP_MAX;
        else cfg_step = value;
      end
      default: ;  // no register behind this index
    endcase
    @(posedge clk);
  endtask

  // Offer one source frame, idling at random first; return at its transfer
  task automatic send_frame(logic [15:0] l_raw, logic [15:0] r_raw, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r_raw, l_raw};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_source_frame(l_raw, r_raw, last);
  endtask

  // Drop valid, wait for every expected frame, then let the block settle
  task automatic wait_for_quiet();
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("ERROR %0t: %s got %h want %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Compare each output transfer with the oldest expectation; drive ready
  always @(posedge clk) begin
    out_frame_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected output transfer, tdata low", m_tdata[15:0], 16'h0);
      end else begin
        want = expected_frames.pop_front();
        if (m_tdata[15:0] !== want.left_out)
          report_mismatch("left_out", m_tdata[15:0], want.left_out);
        if (m_tdata[31:16] !== want.right_out)
          report_mismatch("right_out", m_tdata[31:16], want.right_out);
        if (m_tuser[0] !== want.has_frame)
          report_mismatch("has_frame", 16'(m_tuser[0]), 16'(want.has_frame));
        if (m_tlast !== want.end_of_stream)
          report_mismatch("end_of_stream", 16'(m_tlast), 16'(want.end_of_stream));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Reset registers: a lone frame that is also the last one
  task automatic test_single_last_frame();
    send_frame(16'h8000, 16'h7FFF, 1'b1);
    wait_for_quiet();
  endtask

  // Smallest step (zero write clamps up): full-scale swings, 64 frames from the last item
  task automatic test_max_results();
    write_reg(REG_RATE_STEP, 19'd0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b1);
    wait_for_quiet();
  endtask

  // 8-bit mono: low byte only, right channel ignored
  task automatic test_eight_bit_mono();
    write_reg(REG_SIXTEEN_BIT, 19'd0);
    write_reg(REG_STEREO, 19'd0);
    write_reg(REG_RATE_STEP, 19'd40000);
    send_frame(16'hAB00, 16'h1234, 1'b0);
    send_frame(16'hCDFF, 16'hFFFF, 1'b0);
    send_frame(16'h0080, 16'h0000, 1'b0);
    send_frame(16'h117F, 16'h5555, 1'b1);
    wait_for_quiet();
  endtask

  // Largest step (all-ones write clamps down): skipped intervals, bare end marker
  task automatic test_skipped_intervals();
    write_reg(REG_SIXTEEN_BIT, 19'h7FFFF);
    write_reg(REG_STEREO, 19'h7FFFF);
    write_reg(REG_RATE_STEP, 19'h7FFFF);
    send_frame(16'h1000, 16'hF000, 1'b0);
    send_frame(16'h2000, 16'hE000, 1'b0);
    send_frame(16'h3000, 16'hD000, 1'b0);
    send_frame(16'h4000, 16'hC000, 1'b1);
    wait_for_quiet();
  endtask

  // Step change between frames of one stream, 16-bit mono
  task automatic test_rate_change_mid_stream();
    write_reg(REG_STEREO, 19'd0);
    write_reg(REG_RATE_STEP, 19'd24576);
    send_frame(16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 1'b0);
    wait_for_quiet();
    write_reg(REG_RATE_STEP, 19'd100000);
    send_frame(16'h7FFF, 16'h1111, 1'b0);
    send_frame(16'h8001, 16'h2222, 1'b1);
    wait_for_quiet();
  endtask

  // A write to an index with no register changes nothing
  task automatic test_ignored_index();
    write_reg(REG_STEREO, 19'd1);
    write_reg(REG_UNUSED, 19'h7FFFF);
    send_frame(16'h0123, 16'hFEDC, 1'b0);
    send_frame(16'h8888, 16'h7777, 1'b1);
    wait_for_quiet();
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly legal steps, small ones less often; out-of-range writes now and then
  function automatic logic [18:0] random_step();
    case ($urandom_range(9))
      0:       return STEP_MIN;
      1:       return STEP_MAX;
      2:       return 19'($urandom_range(0, 2047));
      3:       return 19'($urandom_range(262145, 524287));
      4:       return 19'($urandom_range(2048, 16384));
      5, 6:    return 19'($urandom_range(16384, 65536));
      default: return 19'($urandom_range(65536, 262144));
    endcase
  endfunction

  // Streams of random length and content under random register settings
  task automatic test_random_streams(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      wait_for_quiet();
      if ($urandom_range(2) == 0) write_reg(REG_SIXTEEN_BIT, 19'($urandom));
      if ($urandom_range(2) == 0) write_reg(REG_STEREO, 19'($urandom));
      if ($urandom_range(1) == 0) write_reg(REG_RATE_STEP, random_step());
      if ($urandom_range(7) == 0) write_reg(REG_UNUSED, 19'($urandom));
      len = $urandom_range(1, 16);
      for (int k = 0; k < len; k++) begin
        // occasionally retune the step between frames
        if (k > 0 && $urandom_range(11) == 0) begin
          wait_for_quiet();
          write_reg(REG_RATE_STEP, random_step());
        end
        send_frame(random_sample(), random_sample(), k == len - 1);
        sent++;
      end
    end
    wait_for_quiet();
  endtask

  initial begin
    set_idling(31, 53);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_single_last_frame();
    test_max_results();
    test_eight_bit_mono();
    test_skipped_intervals();
    test_rate_change_mid_stream();
    test_ignored_index();
    test_random_streams(150);
    set_idling(53, 31);
    test_random_streams(150);
    set_idling(0, 0);
    test_random_streams(150);
    wait_for_quiet();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pcmli_pkg.sv
hw/rtl/pcmli_interp.sv
hw/rtl/pcm_linear_interp_resampler.sv
tb/sv/tb_pcm_linear_interp_resampler.sv
